FILE: rtl/semseq_pkg.sv
// ----------------------------------------------------------------------------
// semseq_pkg
// Shared types and constants for the servo enable and motion sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package semseq_pkg;

  // Sequencer states, encoded as seen on controller_state
  typedef enum logic [2:0] {
    ST_OFF         = 3'd0,
    ST_RESET_ALARM = 3'd1,
    ST_SERVO_ON    = 3'd2,
    ST_SETUP       = 3'd3,
    ST_IDLE        = 3'd4,
    ST_BUSY        = 3'd5
  } seq_state_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TIMEOUT   = 1'b0,
    REG_BUSY_MASK = 1'b1
  } cfg_reg_t;

  localparam int CFG_DATA_W = 16;

  // Drive control words
  localparam logic [15:0] CW_NONE   = 16'h0000;
  localparam logic [15:0] CW_RESET  = 16'h0800;
  localparam logic [15:0] CW_SVON   = 16'h0200;
  localparam logic [15:0] CW_SETUP  = 16'h1200;
  localparam logic [15:0] FLAGS_ALL = 16'hFFF0;
  localparam logic [15:0] FLAGS_NONE = 16'h0000;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RESET   = 16'd10;
  localparam logic [15:0] BUSY_MASK_RESET = 16'h0100;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] busy_mask;
  } cfg_t;

  // One tick as presented to the sequencer core
  typedef struct packed {
    logic               demand_write;
    logic               demand_enable;
    logic               target_write;
    logic signed [31:0] target_value;
    logic [15:0]        device_status;
  } tick_t;

  // Process values after one tick
  typedef struct packed {
    logic [2:0]         controller_state;
    logic [15:0]        control_word;
    logic [15:0]        change_flags;
    logic               start_flag;
    logic signed [31:0] commanded_position;
    logic               servo_ready;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/semseq_cfg_regs.sv
// ----------------------------------------------------------------------------
// semseq_cfg_regs
// Timeout and busy-mask configuration registers with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module semseq_cfg_regs (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  semseq_pkg::cfg_reg_t         cfg_index,
  input  wire [semseq_pkg::CFG_DATA_W-1:0] cfg_data,
  output semseq_pkg::cfg_t             cfg
);
  import semseq_pkg::*;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.busy_mask     <= BUSY_MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:   cfg.timeout_ticks <= cfg_data;
        REG_BUSY_MASK: cfg.busy_mask     <= cfg_data;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/semseq_core.sv
// ----------------------------------------------------------------------------
// semseq_core
// Sequencer state, tick counter, latched demand and target, and the
// drive-facing process values; steps once per transferred tick.
// ----------------------------------------------------------------------------
`default_nettype none

module semseq_core #(
  parameter int TICK_COUNTER_WIDTH = 16,
  parameter int POSITION_WIDTH     = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  semseq_pkg::tick_t    tick,
  input  semseq_pkg::cfg_t     cfg,
  output semseq_pkg::result_t  result
);
  import semseq_pkg::*;

  localparam int CMP_W = (TICK_COUNTER_WIDTH > 16) ? TICK_COUNTER_WIDTH : 16;

  typedef logic signed [POSITION_WIDTH-1:0] position_t;

  seq_state_t                    state, state_next;
  logic [TICK_COUNTER_WIDTH-1:0] elapsed, elapsed_next, elapsed_inc;
  logic                          demand_on, demand_on_next;
  logic                          pending_valid, pending_valid_next, pending_eff;
  position_t                     pending_target, pending_target_next;
  position_t                     position_out, position_out_next;
  logic [15:0]                   port_word, port_word_next;
  logic                          flags_set, flags_set_next;
  logic                          start_bit, start_bit_next;
  logic                          expired;
  logic                          busy;
  logic                          take;

  // Latch writes carried by this tick ahead of the step
  assign demand_on_next = tick.demand_write ? tick.demand_enable : demand_on;
  assign pending_eff    = tick.target_write | pending_valid;
  assign pending_target_next =
    tick.target_write ? position_t'(tick.target_value[POSITION_WIDTH-1:0]) : pending_target;

  assign busy = |(tick.device_status & cfg.busy_mask);

  // Saturating tick count and timeout test
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + 1'b1;
  assign expired     = CMP_W'(elapsed_inc) > CMP_W'(cfg.timeout_ticks);

  // Next state
  always_comb begin
    state_next = state;
    take       = 1'b0;
    unique case (state)
      ST_OFF: begin
        if (expired && demand_on_next) begin
          state_next = ST_RESET_ALARM;
          take       = 1'b1;
        end
      end
      ST_RESET_ALARM: begin
        if (expired) begin
          state_next = ST_SERVO_ON;
          take       = 1'b1;
        end
      end
      ST_SERVO_ON: begin
        if (expired) begin
          state_next = ST_SETUP;
          take       = 1'b1;
        end
      end
      ST_SETUP: begin
        if (expired && !busy) begin
          state_next = ST_IDLE;
          take       = 1'b1;
        end
      end
      ST_IDLE: begin
        if (expired && !demand_on_next) begin
          state_next = ST_OFF;
          take       = 1'b1;
        end else if (expired && pending_eff) begin
          state_next = ST_BUSY;
          take       = 1'b1;
        end
      end
      ST_BUSY: begin
        if (expired && !busy) begin
          state_next = ST_IDLE;
          take       = 1'b1;
        end
      end
      default: begin
        // unreachable code: fall back to off, keep everything else
        state_next = ST_OFF;
      end
    endcase
  end

  // Process values that follow each transition
  always_comb begin
    elapsed_next       = take ? '0 : elapsed_inc;
    pending_valid_next = pending_eff;
    position_out_next  = position_out;
    port_word_next     = port_word;
    flags_set_next     = flags_set;
    start_bit_next     = start_bit;
    if (take) begin
      unique case (state_next)
        ST_RESET_ALARM: begin
          pending_valid_next = 1'b0;
          position_out_next  = '0;
          port_word_next     = CW_RESET;
        end
        ST_SERVO_ON: begin
          flags_set_next = 1'b1;
          port_word_next = CW_SVON;
        end
        ST_SETUP: begin
          port_word_next = CW_SETUP;
        end
        ST_IDLE: begin
          // back from busy leaves the drive words untouched
          if (state == ST_SETUP) begin
            port_word_next = CW_SVON;
            start_bit_next = 1'b1;
          end
        end
        ST_BUSY: begin
          pending_valid_next = 1'b0;
          position_out_next  = pending_target_next;
        end
        ST_OFF: begin
          port_word_next = CW_NONE;
          start_bit_next = 1'b0;
        end
        default: begin
          port_word_next = port_word;
        end
      endcase
    end
  end

  // Advance on each transferred tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_OFF;
      elapsed        <= '0;
      demand_on      <= 1'b0;
      pending_valid  <= 1'b0;
      pending_target <= '0;
      position_out   <= '0;
      port_word      <= CW_NONE;
      flags_set      <= 1'b0;
      start_bit      <= 1'b0;
    end else if (step) begin
      state          <= state_next;
      elapsed        <= elapsed_next;
      demand_on      <= demand_on_next;
      pending_valid  <= pending_valid_next;
      pending_target <= pending_target_next;
      position_out   <= position_out_next;
      port_word      <= port_word_next;
      flags_set      <= flags_set_next;
      start_bit      <= start_bit_next;
    end
  end

  // Result of this step
  always_comb begin
    result.controller_state   = state_next;
    result.control_word       = port_word_next;
    result.change_flags       = flags_set_next ? FLAGS_ALL : FLAGS_NONE;
    result.start_flag         = start_bit_next;
    result.commanded_position = 32'(position_out_next);
    result.servo_ready        = (state_next == ST_IDLE) || (state_next == ST_BUSY);
  end

endmodule

`default_nettype wire

FILE: rtl/semseq_out_reg.sv
// ----------------------------------------------------------------------------
// semseq_out_reg
// Result register between the sequencer and the output stream; loads a new
// result whenever it is empty or its content is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module semseq_out_reg (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  load_valid,
  output logic                 load_ready,
  input  semseq_pkg::result_t  load_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output semseq_pkg::result_t  out_data
);
  import semseq_pkg::*;

  assign load_ready = !out_valid || out_ready;

  // Hold the valid flag until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load_valid;
    end
  end

  // Capture the payload on load
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/servo_enable_motion_sequencer.sv
// ----------------------------------------------------------------------------
// servo_enable_motion_sequencer
// Servo enable and motion sequencer: one control tick in, one set of drive
// process values out.
// ----------------------------------------------------------------------------
// Result is registered: valid on the master side the cycle after transfer.
// Throughput: 1 tick per cycle unless m_tready stalls; the sequencer steps on
//   the transfer edge; the result register takes a tick when empty or draining.
// Reset (rst, synchronous): sequencer off, counters and latched values zero,
//   timeout 10 ticks, busy mask 0x0100, output stream empty.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_enable_motion_sequencer #(
  parameter int TICK_COUNTER_WIDTH = 16,
  parameter int POSITION_WIDTH     = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  // configuration write port
  input  wire                      cfg_we,
  input  semseq_pkg::cfg_reg_t     cfg_index,
  input  wire [semseq_pkg::CFG_DATA_W-1:0] cfg_data,
  // tick stream
  input  wire                      s_tvalid,
  output logic                     s_tready,
  // demand_enable[0], target_value[32:1], device_status[48:33], zero fill
  input  wire [55:0]               s_tdata,
  // demand_write[0], target_write[1]
  input  wire [1:0]                s_tuser,
  // result stream
  output logic                     m_tvalid,
  input  wire                      m_tready,
  // controller_state[2:0], control_word[18:3], change_flags[34:19],
  // start_flag[35], commanded_position[67:36], servo_ready[68], zero fill
  output logic [71:0]              m_tdata
);
  import semseq_pkg::*;

  cfg_t    cfg;
  tick_t   tick;
  result_t step_result;
  result_t out_result;
  logic    step;

  // Unpack the tick
  always_comb begin
    tick.demand_write  = s_tuser[0];
    tick.target_write  = s_tuser[1];
    tick.demand_enable = s_tdata[0];
    tick.target_value  = s_tdata[32:1];
    tick.device_status = s_tdata[48:33];
  end

  assign step = s_tvalid && s_tready;

  semseq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  semseq_core #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH),
    .POSITION_WIDTH     (POSITION_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .tick   (tick),
    .cfg    (cfg),
    .result (step_result)
  );

  semseq_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s_tvalid),
    .load_ready (s_tready),
    .load_data  (step_result),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_result)
  );

  // Pack the result, first field lowest
  assign m_tdata = {3'b000,
                    out_result.servo_ready,
                    out_result.commanded_position,
                    out_result.start_flag,
                    out_result.change_flags,
                    out_result.control_word,
                    out_result.controller_state};

endmodule

`default_nettype wire
